/* design/flbpc_pkg.sv */
package flbpc_pkg;

  localparam int LedCountDefault = 4;

  localparam int KindW    = 3;
  localparam int IdxW     = 2;
  localparam int PeriodW  = 16;
  localparam int RepeatsW = 8;
  localparam int PatW     = 3;
  localparam int LevelsW  = 4;
  localparam int PtimerW  = 16;
  localparam int SeqW     = 2;

  // The alternate pattern fires every AltPeriod ticks, the sequence pattern
  // every SeqPeriod ticks.
  localparam int AltPeriod = 50;
  localparam int SeqPeriod = 25;
  localparam int PhaseW    = $clog2(AltPeriod);

  typedef enum logic [KindW-1:0] {
    KindTick    = 3'd0,
    KindBlink   = 3'd1,
    KindPattern = 3'd2,
    KindOn      = 3'd3,
    KindOff     = 3'd4,
    KindToggle  = 3'd5
  } kind_e;

  typedef enum logic [PatW-1:0] {
    PatNone      = 3'd0,
    PatAllOn     = 3'd1,
    PatAllOff    = 3'd2,
    PatAlternate = 3'd3,
    PatSequence  = 3'd4
  } pattern_e;

  typedef struct packed {
    logic                tick;
    logic                start;
    logic [PeriodW-1:0]  period;
    logic [RepeatsW-1:0] repeats;
  } chan_cmd_t;

endpackage

/* design/flbpc_channel.sv */
module flbpc_channel
  import flbpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  chan_cmd_t cmd_i,
  output logic      toggle_o,
  output logic      active_o
);

  logic [RepeatsW-1:0] count_q, count_d;
  logic                phase_q, phase_d;
  logic [PeriodW-1:0]  period_q, period_d;
  logic [PeriodW-1:0]  timer_q, timer_d;
  logic [PeriodW-1:0]  timer_inc;

  always_comb begin
    count_d   = count_q;
    phase_d   = phase_q;
    period_d  = period_q;
    timer_d   = timer_q;
    toggle_o  = 1'b0;
    timer_inc = timer_q + PeriodW'(1);
    if (cmd_i.start) begin
      period_d = cmd_i.period;
      count_d  = cmd_i.repeats;
      phase_d  = 1'b0;
      timer_d  = '0;
    end else if (cmd_i.tick && (count_q != '0)) begin
      if (timer_inc >= period_q) begin
        // A full on-off cycle ends when the phase returns to zero.
        timer_d  = '0;
        toggle_o = 1'b1;
        phase_d  = ~phase_q;
        if (phase_q) begin
          count_d = count_q - RepeatsW'(1);
        end
      end else begin
        timer_d = timer_inc;
      end
    end
    active_o = (count_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      phase_q  <= 1'b0;
      period_q <= '0;
      timer_q  <= '0;
    end else if (en_i) begin
      count_q  <= count_d;
      phase_q  <= phase_d;
      period_q <= period_d;
      timer_q  <= timer_d;
    end
  end

endmodule

/* design/four_led_blink_pattern_controller.sv */
// Four-LED blink and pattern controller. Each input item is one command
// (tick, start blink, set pattern, LED on, off or toggle) and yields exactly
// one result item holding the LED levels and the per-channel blink activity
// after that command. The block takes one item per clock cycle while the
// input is not stalled; a result is offered once its item has moved from
// the input register into the result register, with all blink channels,
// the pattern timer and the LED register updated together at that move.
// Stall on the result side holds the result register and, once the input
// register is also full, stalls the input.
module four_led_blink_pattern_controller
  import flbpc_pkg::*;
#(
  parameter int LED_COUNT = LedCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [IdxW-1:0]     led_index_i,
  input  logic [PeriodW-1:0]  blink_period_i,
  input  logic [RepeatsW-1:0] blink_repeats_i,
  input  logic [PatW-1:0]     pattern_select_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LevelsW-1:0]  led_levels_o,
  output logic [LevelsW-1:0]  blink_active_o
);

  localparam int ExtW = (LED_COUNT > LevelsW) ? LED_COUNT : LevelsW;

  logic                s1_valid_q;
  logic [KindW-1:0]    kind_q;
  logic [IdxW-1:0]     idx_q;
  logic [PeriodW-1:0]  period_q;
  logic [RepeatsW-1:0] repeats_q;
  logic [PatW-1:0]     pat_q;

  logic                out_valid_q;
  logic [LevelsW-1:0]  levels_q, levels_d;
  logic [LevelsW-1:0]  active_q, active_d;

  logic [LED_COUNT-1:0] led_q, led_d;
  logic [PatW-1:0]      mode_q, mode_d;
  logic [PtimerW-1:0]   ptimer_q, ptimer_d;
  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [SeqW-1:0]      seq_q, seq_d;

  logic                 advance, s1_ready, in_accept, upd;
  logic [LED_COUNT-1:0] idx_onehot, seq_onehot, toggles, chan_active;
  logic [ExtW-1:0]      led_ext, active_ext;
  kind_e                kind;
  chan_cmd_t            chan_cmd [LED_COUNT];

  assign advance    = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && s1_ready;
  assign upd        = s1_valid_q && advance;
  assign in_stall_o = !s1_ready;
  assign kind       = kind_e'(kind_q);

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      idx_onehot[i] = (32'(idx_q) == i);
      seq_onehot[i] = (32'(seq_q) == i);
    end
  end

  for (genvar g = 0; g < LED_COUNT; g++) begin : g_chan
    always_comb begin
      chan_cmd[g].tick    = (kind == KindTick);
      chan_cmd[g].start   = (kind == KindBlink) && idx_onehot[g];
      chan_cmd[g].period  = period_q;
      chan_cmd[g].repeats = repeats_q;
    end

    flbpc_channel u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (upd),
      .cmd_i    (chan_cmd[g]),
      .toggle_o (toggles[g]),
      .active_o (chan_active[g])
    );
  end

  always_comb begin
    led_d    = led_q;
    mode_d   = mode_q;
    ptimer_d = ptimer_q;
    phase_d  = phase_q;
    seq_d    = seq_q;
    unique case (kind)
      KindTick: begin
        led_d    = led_q ^ toggles;
        ptimer_d = ptimer_q + PtimerW'(1);
        // The phase counter tracks the pattern timer modulo the alternate
        // period and restarts at zero whenever the timer wraps.
        if ((ptimer_q == '1) || (phase_q == PhaseW'(AltPeriod - 1))) begin
          phase_d = '0;
        end else begin
          phase_d = phase_q + PhaseW'(1);
        end
        unique case (pattern_e'(mode_q))
          PatAllOn:  led_d = '1;
          PatAllOff: led_d = '0;
          PatAlternate: begin
            if (phase_d == '0) begin
              led_d = ~led_d;
            end
          end
          PatSequence: begin
            if ((phase_d == '0) || (phase_d == PhaseW'(SeqPeriod))) begin
              led_d = seq_onehot;
              seq_d = seq_q + SeqW'(1);
            end
          end
          default: ;
        endcase
      end
      KindBlink:  led_d = led_q | idx_onehot;
      KindPattern: begin
        mode_d   = pat_q;
        ptimer_d = '0;
        phase_d  = '0;
      end
      KindOn:     led_d = led_q | idx_onehot;
      KindOff:    led_d = led_q & ~idx_onehot;
      KindToggle: led_d = led_q ^ idx_onehot;
      default: ;
    endcase
    led_ext    = ExtW'(led_d);
    active_ext = ExtW'(chan_active);
    levels_d   = led_ext[LevelsW-1:0];
    active_d   = active_ext[LevelsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= kind_i;
      idx_q     <= led_index_i;
      period_q  <= blink_period_i;
      repeats_q <= blink_repeats_i;
      pat_q     <= pattern_select_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      led_q       <= '0;
      mode_q      <= '0;
      ptimer_q    <= '0;
      phase_q     <= '0;
      seq_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (upd) begin
        led_q    <= led_d;
        mode_q   <= mode_d;
        ptimer_q <= ptimer_d;
        phase_q  <= phase_d;
        seq_q    <= seq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      levels_q <= levels_d;
      active_q <= active_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_levels_o   = levels_q;
  assign blink_active_o = active_q;

endmodule

/* design/flbpc_checker.sv */
module flbpc_checker
  import flbpc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [LevelsW-1:0] led_levels_o,
  input logic [LevelsW-1:0] blink_active_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(led_levels_o) && $stable(blink_active_o))
    else $error("stalled result changed or was dropped");

  // The input only stalls while a result is held back by the output side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A stalled input means an item is waiting, so a result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("result vanished while an item was waiting");

  // Once reset has been seen held, no result is offered and nothing stalls.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("handshake active during reset");

endmodule

bind four_led_blink_pattern_controller flbpc_checker u_flbpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .led_levels_o   (led_levels_o),
  .blink_active_o (blink_active_o)
);
